/* sv/text_console_cell_writer_assert.svh */
// ---------------------------------------------------------------------------
// text console cell writer assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled during synchronous reset
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tcw assertion failed: same-cycle implication");

// next-cycle implication
`define TCW_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tcw assertion failed: next-cycle implication");

`endif

/* sv/tcw_pkg.sv */
// ---------------------------------------------------------------------------
// tcw_pkg
// shared types, codes and constants of the text console cell writer
// ---------------------------------------------------------------------------
package tcw_pkg;

   // default screen geometry
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // fixed field widths
   localparam int POS_W  = 11;
   localparam int CELL_W = 16;

   localparam logic [7:0]        ATTR_RESET = 8'd15;
   localparam logic [CELL_W-1:0] ATTR_MASK  = 16'hff00;
   localparam int                TAB_STEP   = 4;

   // command codes
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // control bytes
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_CR  = 8'd13;

   // cell sweep modes
   localparam logic [1:0] SWEEP_ZERO = 2'd0;  // write zero
   localparam logic [1:0] SWEEP_COPY = 2'd1;  // move up one row
   localparam logic [1:0] SWEEP_KEEP = 2'd2;  // clear char, keep attribute

   typedef struct packed {
      logic [1:0]       command;
      logic [7:0]       char_code;
      logic [POS_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic [CELL_W-1:0] read_data;
      logic              scrolled;
   } rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       cursor_put;
      logic       cursor_home;
      logic       capture_read;
      logic       sweep_start;
      logic [1:0] sweep_mode;
      logic       sweep_last_row;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       need_scroll;
      logic       sweep_busy;
   } dp_sts_type;

endpackage

/* sv/tcw_datapath.sv */
// ---------------------------------------------------------------------------
// tcw_datapath
// cell memory, cursor registers, cell sweep engine and result register
// ---------------------------------------------------------------------------
`include "text_console_cell_writer_assert.svh"

module tcw_datapath #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  tcw_pkg::req_type    req_data,
   input  logic                csr_write_enable,
   input  logic [7:0]          csr_write_data,
   input  tcw_pkg::dp_cmd_type cmd,
   output tcw_pkg::dp_sts_type sts,
   output tcw_pkg::rsp_type    rsp_data
);

   localparam int CELL_COUNT     = COLUMNS * ROWS;
   localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W         = $clog2(CELL_COUNT);
   localparam int OFF_W          = $clog2(CELL_COUNT + COLUMNS);
   localparam int COL_W          = $clog2(COLUMNS);
   localparam int COLS_W         = COL_W + 1;
   localparam int POS_W          = tcw_pkg::POS_W;
   localparam int CELL_W         = tcw_pkg::CELL_W;

   // cell memory
   logic [CELL_W-1:0] cells_mem [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [CELL_W-1:0] mem_wdata;

   tcw_pkg::req_type  req_ff;
   logic [7:0]        attr_ff, attr_in;
   logic [OFF_W-1:0]  cursor_ff, cursor_in;
   logic [OFF_W-1:0]  row_start_ff, row_start_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CELL_W-1:0] res_read_ff, res_read_in;
   logic              res_scroll_ff, res_scroll_in;
   tcw_pkg::rsp_type  rsp_ff;

   // sweep engine
   logic              run_ff, run_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [1:0]        sweep_mode_ff, sweep_mode_in;
   logic              wr_pend_ff;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0] sweep_wdata;

   // put decode
   logic              is_newline, is_bs, is_tab, printable;
   logic [COLS_W-1:0] col_sum;
   logic [OFF_W-1:0]  put_off, put_row;
   logic [COL_W-1:0]  put_col;
   logic              need_scroll;
   logic              index_ok;

   assign is_newline = (req_ff.char_code == tcw_pkg::CH_LF) ||
                       (req_ff.char_code == tcw_pkg::CH_CR);
   assign is_bs      = (req_ff.char_code == tcw_pkg::CH_BS);
   assign is_tab     = (req_ff.char_code == tcw_pkg::CH_TAB);
   assign printable  = !is_newline && !is_bs && !is_tab;
   assign index_ok   = (int'(req_ff.cell_index) < CELL_COUNT);

   always_comb begin
      put_off = cursor_ff;
      put_row = row_start_ff;
      put_col = col_ff;
      col_sum = {1'b0, col_ff} + (is_tab ? COLS_W'(tcw_pkg::TAB_STEP) : COLS_W'(1));
      if (is_newline) begin
         put_off = row_start_ff + OFF_W'(COLUMNS);
         put_row = row_start_ff + OFF_W'(COLUMNS);
         put_col = '0;
      end else if (is_bs) begin
         if (cursor_ff != '0) begin
            put_off = cursor_ff - OFF_W'(1);
            if (col_ff == '0) begin
               put_col = COL_W'(COLUMNS - 1);
               put_row = row_start_ff - OFF_W'(COLUMNS);
            end else begin
               put_col = col_ff - COL_W'(1);
            end
         end
      end else begin
         put_off = cursor_ff + (is_tab ? OFF_W'(tcw_pkg::TAB_STEP) : OFF_W'(1));
         if (col_sum >= COLS_W'(COLUMNS)) begin
            put_col = COL_W'(col_sum - COLS_W'(COLUMNS));
            put_row = row_start_ff + OFF_W'(COLUMNS);
         end else begin
            put_col = COL_W'(col_sum);
         end
      end
   end

   assign need_scroll = (put_off >= OFF_W'(CELL_COUNT));

   // cursor, attribute and result fields
   always_comb begin
      attr_in       = attr_ff;
      cursor_in     = cursor_ff;
      row_start_in  = row_start_ff;
      col_in        = col_ff;
      res_read_in   = res_read_ff;
      res_scroll_in = res_scroll_ff;
      if (csr_write_enable) begin
         attr_in = csr_write_data;
      end
      if (cmd.load_req) begin
         res_read_in   = '0;
         res_scroll_in = 1'b0;
      end
      if (cmd.cursor_put) begin
         if (need_scroll) begin
            cursor_in     = OFF_W'(LAST_ROW_START);
            row_start_in  = OFF_W'(LAST_ROW_START);
            col_in        = '0;
            res_scroll_in = 1'b1;
         end else begin
            cursor_in    = put_off;
            row_start_in = put_row;
            col_in       = put_col;
         end
      end
      if (cmd.cursor_home) begin
         cursor_in    = '0;
         row_start_in = '0;
         col_in       = '0;
      end
      if (cmd.capture_read) begin
         res_read_in = index_ok ? rd_data_ff : '0;
      end
   end

   // sweep address sequencing
   always_comb begin
      run_in        = run_ff;
      sweep_in      = sweep_ff;
      sweep_mode_in = sweep_mode_ff;
      if (cmd.sweep_start) begin
         run_in        = 1'b1;
         sweep_mode_in = cmd.sweep_mode;
         if (cmd.sweep_mode == tcw_pkg::SWEEP_COPY) begin
            sweep_in = ADDR_W'(COLUMNS);
         end else if (cmd.sweep_last_row) begin
            sweep_in = ADDR_W'(LAST_ROW_START);
         end else begin
            sweep_in = '0;
         end
      end else if (run_ff) begin
         sweep_in = sweep_ff + ADDR_W'(1);
         if (sweep_ff == ADDR_W'(CELL_COUNT - 1)) begin
            run_in = 1'b0;
         end
      end
      wr_addr_in = (sweep_mode_ff == tcw_pkg::SWEEP_COPY) ?
                   sweep_ff - ADDR_W'(COLUMNS) : sweep_ff;
   end

   always_comb begin
      case (sweep_mode_ff)
         tcw_pkg::SWEEP_ZERO: sweep_wdata = '0;
         tcw_pkg::SWEEP_COPY: sweep_wdata = rd_data_ff;
         default:             sweep_wdata = rd_data_ff & tcw_pkg::ATTR_MASK;
      endcase
   end

   // memory ports: the sweep owns them while it runs
   assign mem_raddr = run_ff ? sweep_ff : ADDR_W'(req_ff.cell_index);
   assign mem_we    = wr_pend_ff || (cmd.cursor_put && printable);
   assign mem_waddr = wr_pend_ff ? wr_addr_ff : cursor_ff[ADDR_W-1:0];
   assign mem_wdata = wr_pend_ff ? sweep_wdata : {attr_ff, req_ff.char_code};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cells_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff       <= tcw_pkg::ATTR_RESET;
         cursor_ff     <= '0;
         row_start_ff  <= '0;
         col_ff        <= '0;
         run_ff        <= 1'b0;
         sweep_ff      <= '0;
         sweep_mode_ff <= tcw_pkg::SWEEP_ZERO;
         wr_pend_ff    <= 1'b0;
      end else begin
         attr_ff       <= attr_in;
         cursor_ff     <= cursor_in;
         row_start_ff  <= row_start_in;
         col_ff        <= col_in;
         run_ff        <= run_in;
         sweep_ff      <= sweep_in;
         sweep_mode_ff <= sweep_mode_in;
         wr_pend_ff    <= run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      wr_addr_ff    <= wr_addr_in;
      res_read_ff   <= res_read_in;
      res_scroll_ff <= res_scroll_in;
      if (cmd.rsp_load) begin
         rsp_ff.cursor_position <= POS_W'(cursor_ff);
         rsp_ff.read_data       <= res_read_ff;
         rsp_ff.scrolled        <= res_scroll_ff;
      end
   end

   assign sts.command     = req_ff.command;
   assign sts.need_scroll = need_scroll;
   assign sts.sweep_busy  = run_ff || wr_pend_ff;
   assign rsp_data        = rsp_ff;

   `TCW_ASSERT_IMPLY(a_cursor_range, clock, reset, 1'b1, cursor_ff < OFF_W'(CELL_COUNT))
   `TCW_ASSERT_IMPLY(a_cursor_split, clock, reset, 1'b1, cursor_ff == row_start_ff + OFF_W'(col_ff))
   `TCW_ASSERT_IMPLY(a_put_no_sweep, clock, reset, cmd.cursor_put, !run_ff && !wr_pend_ff)

endmodule

/* sv/tcw_ctrl.sv */
// ---------------------------------------------------------------------------
// tcw_ctrl
// command sequencer and handshake control of the text console cell writer
// ---------------------------------------------------------------------------
`include "text_console_cell_writer_assert.svh"

module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tcw_pkg::dp_cmd_type cmd,
   input  tcw_pkg::dp_sts_type sts
);

   localparam logic [2:0] S_INIT       = 3'd0;
   localparam logic [2:0] S_INIT_WAIT  = 3'd1;
   localparam logic [2:0] S_IDLE       = 3'd2;
   localparam logic [2:0] S_EXEC       = 3'd3;
   localparam logic [2:0] S_READ_WAIT  = 3'd4;
   localparam logic [2:0] S_COPY_WAIT  = 3'd5;
   localparam logic [2:0] S_CLEAR_WAIT = 3'd6;
   localparam logic [2:0] S_DONE       = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_INIT: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_mode  = tcw_pkg::SWEEP_ZERO;
            state_in        = S_INIT_WAIT;
         end
         S_INIT_WAIT: begin
            if (!sts.sweep_busy) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.command)
               tcw_pkg::CMD_PUT: begin
                  cmd.cursor_put = 1'b1;
                  if (sts.need_scroll) begin
                     cmd.sweep_start = 1'b1;
                     cmd.sweep_mode  = tcw_pkg::SWEEP_COPY;
                     state_in        = S_COPY_WAIT;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               tcw_pkg::CMD_READ: begin
                  state_in = S_READ_WAIT;
               end
               tcw_pkg::CMD_CLEAR: begin
                  cmd.cursor_home = 1'b1;
                  cmd.sweep_start = 1'b1;
                  cmd.sweep_mode  = tcw_pkg::SWEEP_KEEP;
                  state_in        = S_CLEAR_WAIT;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ_WAIT: begin
            cmd.capture_read = 1'b1;
            state_in         = S_DONE;
         end
         S_COPY_WAIT: begin
            if (!sts.sweep_busy) begin
               cmd.sweep_start    = 1'b1;
               cmd.sweep_mode     = tcw_pkg::SWEEP_KEEP;
               cmd.sweep_last_row = 1'b1;
               state_in           = S_CLEAR_WAIT;
            end
         end
         S_CLEAR_WAIT: begin
            if (!sts.sweep_busy) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `TCW_ASSERT_IMPLY(a_idle_no_sweep, clock, reset, state_ff == S_IDLE, !sts.sweep_busy)
   `TCW_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.rsp_load, rsp_valid_ff)
   `TCW_ASSERT_IMPLY(a_valid_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DONE)

endmodule

/* sv/text_console_cell_writer.sv */
// ---------------------------------------------------------------------------
// text_console_cell_writer
// text screen of attribute/character cells with a cursor: put, read, clear
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake                  payload
//   req_     in         req_valid / req_stall      tcw_pkg::req_type
//   rsp_     out        rsp_valid / rsp_stall      tcw_pkg::rsp_type
//   csr_     in         csr_write_enable           csr_write_data (attribute)
//
// put and unused commands go from exec straight to done; a read also passes a wait
// state for the registered cell memory read; a put that runs off the screen adds a
// row move sweep plus a bottom row clear, and a clear sweeps the whole screen,
// both at one memory write per cycle through the cell memory
// after reset a clearing pass zeroes all COLUMNS*ROWS cells with req_stall high;
// attribute writes are taken at any time
// the result sits in an output register, so the next item is taken while it waits
// ---------------------------------------------------------------------------

module text_console_cell_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // item input
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::req_type req_data,
   // result output
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcw_pkg::rsp_type rsp_data,
   // attribute register
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data
);

   // command and status between sequencer and datapath
   tcw_pkg::dp_cmd_type cmd;
   tcw_pkg::dp_sts_type sts;

   // sequencer: reset clearing pass, per-command steps, result handshake
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // cell memory, cursor, sweep engine and output register
   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_data         (rsp_data)
   );

endmodule

/* tb/sv/text_console_cell_writer_checker.sv */
// ---------------------------------------------------------------------------
// text_console_cell_writer_checker
// watches the item and result channels and the attribute port of the text
// console cell writer, keeps its own screen, cursor and attribute, works out
// the result of every accepted item and compares it with the result that
// comes out, oldest first
// ---------------------------------------------------------------------------

module text_console_cell_writer_checker
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_COLS    = COLUMNS_DEF;
   localparam int SCREEN_ROWS    = ROWS_DEF;
   localparam int CELL_COUNT     = SCREEN_COLS * SCREEN_ROWS;
   localparam int LAST_ROW_START = (SCREEN_ROWS - 1) * SCREEN_COLS;

   logic [CELL_W-1:0] cells [CELL_COUNT];
   int                cursor;
   logic [7:0]        text_attr;
   rsp_type           expected_q [$];
   int                errors = 0;

   // drop the character of every cell from a position on, attributes stay
   function automatic void wipe_chars(int from);
      for (int i = from; i < CELL_COUNT; i++) begin
         cells[i] = cells[i] & ATTR_MASK;
      end
   endfunction

   // apply one item to the screen and return the result it produces
   function automatic rsp_type console_step(req_type item);
      rsp_type res;
      int      pos;
      res = '0;
      pos = cursor;
      case (item.command)
         CMD_PUT: begin
            if (item.char_code == CH_LF || item.char_code == CH_CR) begin
               pos = pos + SCREEN_COLS - pos % SCREEN_COLS;
            end else if (item.char_code == CH_BS) begin
               if (pos > 0) pos--;
            end else if (item.char_code == CH_TAB) begin
               pos += TAB_STEP;
            end else begin
               cells[pos] = {text_attr, item.char_code};
               pos++;
            end
            if (pos >= CELL_COUNT) begin
               // move every row up by one, bottom row keeps only attributes
               for (int i = 0; i < LAST_ROW_START; i++) begin
                  cells[i] = cells[i + SCREEN_COLS];
               end
               wipe_chars(LAST_ROW_START);
               pos = LAST_ROW_START;
               res.scrolled = 1'b1;
            end
            cursor = pos;
         end
         CMD_READ: begin
            if (item.cell_index < CELL_COUNT) res.read_data = cells[item.cell_index];
         end
         CMD_CLEAR: begin
            wipe_chars(0);
            cursor = 0;
         end
         default: begin
         end
      endcase
      res.cursor_position = POS_W'(cursor);
      return res;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (cells[i]) cells[i] = '0;
         cursor    = 0;
         text_attr = ATTR_RESET;
         expected_q.delete();
      end else begin
         if (csr_write_enable) text_attr = csr_write_data;
         // the result leaving now can only belong to an item already taken
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got cursor %0d data %h scrolled %0d",
                        $time, rsp_data.cursor_position, rsp_data.read_data, rsp_data.scrolled);
            end else begin
               want = expected_q.pop_front();
               check_field("cursor_position", 32'(want.cursor_position),
                           32'(rsp_data.cursor_position));
               check_field("read_data", 32'(want.read_data), 32'(rsp_data.read_data));
               check_field("scrolled", 32'(want.scrolled), 32'(rsp_data.scrolled));
            end
         end
         if (req_valid && !req_stall) expected_q.push_back(console_step(req_data));
      end
      fail_count    <= errors;
      pending_count <= expected_q.size();
   end

endmodule

/* tb/sv/tb_text_console_cell_writer.sv */
// ---------------------------------------------------------------------------
// tb_text_console_cell_writer
// drives put, read, clear and unused commands into the text console cell
// writer with random gaps and result stalls, changes the attribute between
// phases and leaves prediction and comparison to the checker beside it
// ---------------------------------------------------------------------------

module tb_text_console_cell_writer;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   // command 3 has no meaning and must leave the screen alone
   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam logic [7:0] CTRL_CODES [4] = '{CH_BS, CH_TAB, CH_LF, CH_CR};
   localparam int         RANDOM_ITEMS = 450;
   // slowest correct run: the clearing pass after reset, then ~480 items that
   // each sweep the whole screen behind the longest gap and the longest result
   // stall; the limit is four times that
   localparam int         CYCLE_LIMIT  = 4_000_000;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   req_type    req_data         = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data   = '0;

   int         fail_count;
   int         pending_count;
   int         cycle_count = 0;
   int         items_sent  = 0;
   int         stall_left  = 0;
   logic       stall_on    = 1'b1;  // receiver may stall
   bit         gap_on      = 1'b1;  // sender may leave gaps

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   text_console_cell_writer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   text_console_cell_writer_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // result stalls come in random bursts while allowed
   always @(posedge clock) begin
      if (reset || !stall_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic req_type make_req(logic [1:0] cmd, logic [7:0] ch, logic [10:0] idx);
      req_type item;
      item.command    = cmd;
      item.char_code  = ch;
      item.cell_index = idx;
      return item;
   endfunction

   // hand one item over; valid stays high afterwards unless a gap follows
   task automatic send_item(req_type item);
      if (gap_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // cell_index means nothing to a put, so it carries random bits
   task automatic put_char(logic [7:0] ch);
      send_item(make_req(CMD_PUT, ch, 11'($urandom_range(0, 2047))));
   endtask

   task automatic read_cell(logic [10:0] idx);
      send_item(make_req(CMD_READ, 8'($urandom_range(0, 255)), idx));
   endtask

   // stop sending and wait until every result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // the attribute is only changed with the block idle
   task automatic set_attribute(logic [7:0] attr);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= attr;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int          random_base;
      int          done;
      int          kind;
      int          len;
      logic [7:0]  ch;
      logic [10:0] idx;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // fresh screen reads zero everywhere, also past the last cell
      read_cell(11'd0);
      read_cell(11'd1999);
      read_cell(11'h7ff);
      // printable bytes at both ends of the range with the reset attribute
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hff);
      read_cell(11'd0);
      read_cell(11'd2);
      // control bytes: backspace, tab, newline, carriage return
      put_char(CH_BS);
      put_char(CH_TAB);
      put_char(CH_LF);
      put_char(8'h78);
      put_char(CH_CR);
      send_item(make_req(CMD_UNUSED, 8'hff, 11'h7ff));
      // extreme attributes, each set with the block drained
      set_attribute(8'hff);
      put_char(8'h5a);
      read_cell(11'd160);
      set_attribute(8'h00);
      put_char(8'h7e);
      read_cell(11'd161);
      // clear keeps attributes and homes the cursor
      send_item(make_req(CMD_CLEAR, 8'h00, 11'd0));
      read_cell(11'd160);
      // backspace at the first cell stays there
      put_char(CH_BS);
      read_cell(11'd0);
      set_attribute(8'h1e);

      // --- random part ---
      // mostly text lines and control runs so the cursor reaches the last
      // row and scrolls by newline, tab and wrap; reads, clears, unused
      // commands and raw bytes in between
      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         done = items_sent - random_base;
         if (done >= 320) begin
            // last stretch runs with no idling at all
            gap_on = 1'b0;
            stall_on <= 1'b0;
         end else if (done >= 150) begin
            gap_on = 1'($urandom_range(0, 1));
            stall_on <= 1'($urandom_range(0, 1));
         end
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            // a line of text, usually short, now and then wider than a row
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 12);
            repeat (len) begin
               do ch = 8'($urandom_range(0, 255));
               while (ch == CH_BS || ch == CH_TAB || ch == CH_LF || ch == CH_CR);
               put_char(ch);
            end
            if ($urandom_range(0, 9) < 7) put_char($urandom_range(0, 1) ? CH_LF : CH_CR);
         end else if (kind < 64) begin
            repeat ($urandom_range(1, 6)) put_char(CTRL_CODES[$urandom_range(0, 3)]);
         end else if (kind < 70) begin
            // about a row's worth of tabs, which can cross the end when on the last row
            repeat ($urandom_range(18, 22)) put_char(CH_TAB);
         end else if (kind < 88) begin
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 9))
                  0:       idx = 11'($urandom_range(2000, 2047));
                  1, 2, 3: idx = 11'($urandom_range(1600, 1999));
                  default: idx = 11'($urandom_range(0, 1999));
               endcase
               read_cell(idx);
            end
         end else if (kind < 91) begin
            send_item(make_req(CMD_CLEAR, 8'($urandom_range(0, 255)),
                               11'($urandom_range(0, 2047))));
         end else if (kind < 94) begin
            send_item(make_req(CMD_UNUSED, 8'($urandom_range(0, 255)),
                               11'($urandom_range(0, 2047))));
         end else if (kind < 97) begin
            put_char(8'($urandom_range(0, 255)));
         end else if (done < 320) begin
            // attribute changes drain the block, so none in the last stretch
            set_attribute(8'($urandom_range(0, 255)));
         end
      end

      // wait out every result, then idle on for anything stray
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
